>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vmb_pkg.sv
// ----------------------------------------------------------------------------
// vmb_pkg
// Types, widths and arithmetic helpers of the view matrix builder.
// ----------------------------------------------------------------------------
package vmb_pkg;

    localparam int COMP_W    = 32;
    localparam int ROOT_W    = 32;
    localparam int QUOT_W    = 32;
    localparam int UNIT_BITS = 30;
    localparam int SHIFT_W   = 34;
    localparam int PRE_STAGES = 6;
    // Front stages, root stages, divider (one setup stage plus one per bit), sign stage.
    localparam int NORM_LAT  = PRE_STAGES + ROOT_W + 1 + QUOT_W + 1;

    typedef logic [COMP_W-1:0] mag_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [34:0] rnd_t;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } vec_mag_t;

    // Left shift that brings a nonzero largest magnitude into [2^30, 2^32).
    function automatic logic [4:0] norm_shift(input mag_t top);
        logic [4:0] pos;
        logic [4:0] sh;
        pos = '0;
        for (int b = 0; b < COMP_W; b++) begin
            if (top[b]) pos = 5'(b);
        end
        if (top[COMP_W-1] || (top == '0)) sh = '0;
        else sh = 5'(UNIT_BITS) - pos;
        return sh;
    endfunction

    function automatic prod_t smul(input logic [31:0] a, input logic [31:0] b);
        prod_t ea;
        prod_t eb;
        ea = {{32{a[31]}}, a};
        eb = {{32{b[31]}}, b};
        return ea * eb;
    endfunction

    // Divide by 2^30, rounding half away from zero.
    function automatic rnd_t round_unit(input prod_t x);
        logic [63:0] m;
        logic [34:0] r;
        m = x[63] ? (~x + 64'd1) : x;
        r = 35'((m + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS);
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

endpackage

>>> rtl/vmb_in_if.sv
// ----------------------------------------------------------------------------
// vmb_in_if
// Request channel: camera position and viewing direction.
// ----------------------------------------------------------------------------
interface vmb_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;

    modport source (output valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
                    input ready);
    modport sink   (input valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
                    output ready);
endinterface

>>> rtl/vmb_out_if.sv
// ----------------------------------------------------------------------------
// vmb_out_if
// Result channel: rotation rows, translation column and degenerate flag.
// ----------------------------------------------------------------------------
interface vmb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] right_x;
    logic signed [31:0] right_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic signed [31:0] fwd_x;
    logic signed [31:0] fwd_y;
    logic signed [31:0] fwd_z;
    logic signed [33:0] shift_x;
    logic signed [33:0] shift_y;
    logic signed [33:0] shift_z;
    logic               degenerate;

    modport source (output valid, right_x, right_z, up_x, up_y, up_z, fwd_x, fwd_y,
                    fwd_z, shift_x, shift_y, shift_z, degenerate, input ready);
    modport sink   (input valid, right_x, right_z, up_x, up_y, up_z, fwd_x, fwd_y,
                    fwd_z, shift_x, shift_y, shift_z, degenerate, output ready);
endinterface

>>> rtl/vmb_isqrt.sv
// ----------------------------------------------------------------------------
// vmb_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vmb_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [63:0]        radicand,
    input  vmb_pkg::vec_mag_t  in_vec,
    output logic               out_valid,
    output logic [31:0]        root,
    output vmb_pkg::vec_mag_t  out_vec
);

    localparam int N = vmb_pkg::ROOT_W;

    logic [63:0]       rem_reg [N];
    logic [31:0]       res_reg [N];
    vmb_pkg::vec_mag_t vec_reg [N];
    logic              vld_reg [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;
        logic [63:0]       rem_in;
        logic [31:0]       res_in;
        vmb_pkg::vec_mag_t vec_in;
        logic              vld_in;
        logic [64:0]       trial;
        logic              take;

        if (j == 0) begin : g_first
            assign rem_in = radicand;
            assign res_in = '0;
            assign vec_in = in_vec;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
            assign vec_in = vec_reg[j-1];
            assign vld_in = vld_reg[j-1];
        end

        // (res + 2^K)^2 - res^2 = res * 2^(K+1) + 2^(2K)
        always_comb
        begin
            trial = ({33'b0, res_in} << (K + 1)) + (65'd1 << (2 * K));
            take  = ({1'b0, rem_in} >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? (rem_in - trial[63:0]) : rem_in;
                res_reg[j] <= take ? (res_in | (32'd1 << K)) : res_in;
                vec_reg[j] <= vec_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = res_reg[N-1];
    assign out_vec   = vec_reg[N-1];

endmodule

>>> rtl/vmb_div3.sv
// ----------------------------------------------------------------------------
// vmb_div3
// Three-lane pipelined restoring divider: (mag * 2^30 + len / 2) / len.
// ----------------------------------------------------------------------------
module vmb_div3 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [31:0]        len,
    input  vmb_pkg::vec_mag_t  in_vec,
    output logic               out_valid,
    output logic [2:0][31:0]   quot,
    output logic [2:0]         neg
);

    localparam int N = vmb_pkg::QUOT_W;

    logic [2:0][29:0] pre_hi_reg;
    logic [2:0][31:0] pre_lo_reg;
    logic [31:0]      pre_len_reg;
    logic [2:0]       pre_neg_reg;
    logic             pre_vld_reg;

    logic [2:0][31:0] r_reg   [N];
    logic [2:0][31:0] lo_reg  [N];
    logic [2:0][31:0] q_reg   [N];
    logic [31:0]      len_reg [N];
    logic [2:0]       neg_reg [N];
    logic             vld_reg [N];

    // The numerator stays below len * 2^32, so its top bits start below len.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                {pre_hi_reg[i], pre_lo_reg[i]} <=
                    ({30'b0, in_vec.mag[i]} << vmb_pkg::UNIT_BITS) + {31'b0, len[31:1]};
            end
            pre_len_reg <= len;
            pre_neg_reg <= in_vec.neg;
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;
        logic [2:0][31:0] r_in;
        logic [2:0][31:0] lo_in;
        logic [2:0][31:0] q_in;
        logic [31:0]      len_in;
        logic [2:0]       neg_in;
        logic             vld_in;
        logic [2:0][31:0] r_next;
        logic [2:0][31:0] q_next;

        if (j == 0) begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r_in[i] = {2'b0, pre_hi_reg[i]};
                end
            end
            assign lo_in  = pre_lo_reg;
            assign q_in   = '0;
            assign len_in = pre_len_reg;
            assign neg_in = pre_neg_reg;
            assign vld_in = pre_vld_reg;
        end else begin : g_next
            assign r_in   = r_reg[j-1];
            assign lo_in  = lo_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign len_in = len_reg[j-1];
            assign neg_in = neg_reg[j-1];
            assign vld_in = vld_reg[j-1];
        end

        always_comb
        begin
            logic [32:0] cand;
            logic [32:0] diff;
            for (int i = 0; i < 3; i++)
            begin
                cand = {r_in[i], lo_in[i][K]};
                diff = cand - {1'b0, len_in};
                if (cand >= {1'b0, len_in})
                begin
                    r_next[i] = diff[31:0];
                    q_next[i] = q_in[i] | (32'd1 << K);
                end
                else
                begin
                    r_next[i] = cand[31:0];
                    q_next[i] = q_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= r_next;
                q_reg[j]   <= q_next;
                lo_reg[j]  <= lo_in;
                len_reg[j] <= len_in;
                neg_reg[j] <= neg_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quot      = q_reg[N-1];
    assign neg       = neg_reg[N-1];

endmodule

>>> rtl/vmb_norm.sv
// ----------------------------------------------------------------------------
// vmb_norm
// Pipelined normalization of a three-component vector to a Q2.30 unit vector.
// ----------------------------------------------------------------------------
module vmb_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2:0][32:0] vec,
    output logic             out_valid,
    output logic [2:0][31:0] unit
);

    logic [2:0][31:0] mag_reg;
    logic [2:0]       neg1_reg;
    logic [2:0][31:0] mag2_reg;
    logic [2:0]       neg2_reg;
    logic [31:0]      top_reg;
    logic [2:0][31:0] mag3_reg;
    logic [2:0]       neg3_reg;
    logic [4:0]       shamt_reg;
    logic [2:0][31:0] sm4_reg;
    logic [2:0]       neg4_reg;
    logic [2:0][63:0] sq5_reg;
    logic [2:0][31:0] sm5_reg;
    logic [2:0]       neg5_reg;
    logic [63:0]      sum6_reg;
    logic [2:0][31:0] sm6_reg;
    logic [2:0]       neg6_reg;
    logic [5:0]       vld_reg;

    vmb_pkg::vec_mag_t root_vec_in;
    vmb_pkg::vec_mag_t root_vec_out;
    logic              root_vld;
    logic [31:0]       root;
    logic              div_vld;
    logic [2:0][31:0]  quot;
    logic [2:0]        quot_neg;
    logic [2:0][31:0]  unit_reg;
    logic              unit_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            unit_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[4:0], in_valid};
            unit_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= vec[i][32] ? 32'(~vec[i] + 33'd1) : vec[i][31:0];
                neg1_reg[i] <= vec[i][32];
                sm4_reg[i]  <= mag3_reg[i] << shamt_reg;
                sq5_reg[i]  <= {32'b0, sm4_reg[i]} * {32'b0, sm4_reg[i]};
                unit_reg[i] <= quot_neg[i] ? (~quot[i] + 32'd1) : quot[i];
            end
            mag2_reg <= mag_reg;
            neg2_reg <= neg1_reg;
            top_reg  <= (mag_reg[0] >= mag_reg[1]) ?
                        ((mag_reg[0] >= mag_reg[2]) ? mag_reg[0] : mag_reg[2]) :
                        ((mag_reg[1] >= mag_reg[2]) ? mag_reg[1] : mag_reg[2]);
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            shamt_reg <= vmb_pkg::norm_shift(top_reg);
            neg4_reg  <= neg3_reg;
            sm5_reg   <= sm4_reg;
            neg5_reg  <= neg4_reg;
            sum6_reg  <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            sm6_reg   <= sm5_reg;
            neg6_reg  <= neg5_reg;
        end
    end

    assign root_vec_in.neg = neg6_reg;
    assign root_vec_in.mag = sm6_reg;

    vmb_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[5]),
        .radicand  (sum6_reg),
        .in_vec    (root_vec_in),
        .out_valid (root_vld),
        .root      (root),
        .out_vec   (root_vec_out)
    );

    vmb_div3 u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_vld),
        .len       (root),
        .in_vec    (root_vec_out),
        .out_valid (div_vld),
        .quot      (quot),
        .neg       (quot_neg)
    );

    assign out_valid = unit_vld_reg;
    assign unit      = unit_reg;

endmodule

>>> rtl/view_matrix_builder_unit.sv
// ----------------------------------------------------------------------------
// view_matrix_builder_unit
// Look-at view matrix builder: rotation rows and translation in fixed point.
// ----------------------------------------------------------------------------
// A request on view_in carries a camera position and a viewing direction.
// Each request gives one result on view_out: the right row (x and z only),
// the up row and the forward row in Q2.30, and the translation column with
// the camera's fraction bits. A direction with zero x and z sets degenerate
// and clears every other field.
// From request to result, a request passes through the two
// normalizers (magnitude, scaling and squares, a 32-stage square root, a
// 33-stage divider, sign) and then through the products and rounding.
// The pipeline takes one request per cycle while view_out is ready or its
// output register is empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and view_in.ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module view_matrix_builder_unit (
    input  logic     clk,
    input  logic     rst_n,
    vmb_in_if.sink   view_in,
    vmb_out_if.source view_out
);

    localparam int LAT = vmb_pkg::NORM_LAT;

    typedef struct packed {
        logic             deg;
        logic [2:0][31:0] cam;
    } cam_t;

    typedef struct packed {
        logic             deg;
        logic [2:0][31:0] cam;
        logic [31:0]      ux;
        logic [31:0]      uz;
        logic [2:0][31:0] n;
        logic [2:0][31:0] v;
        logic [33:0]      sh0;
        logic [33:0]      sh2;
    } mat_t;

    logic             en;
    logic [2:0][32:0] look_vec;
    logic [2:0][32:0] right_vec;
    logic             n_vld;
    logic             u_vld;
    logic [2:0][31:0] n_unit;
    logic [2:0][31:0] u_unit;
    cam_t             cam_in;
    cam_t             cam_dly_reg [LAT];

    mat_t              m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    mat_t              m3_next;
    logic [4:0]        vld_reg;
    vmb_pkg::prod_t    pv0_reg, pv1a_reg, pv1b_reg, pv2_reg;
    vmb_pkg::prod_t    ps0a_reg, ps0b_reg;
    vmb_pkg::prod_t    ps2_reg [3];
    vmb_pkg::prod_t    vs_reg [3];
    vmb_pkg::prod_t    s0s_reg, s2s_reg;
    vmb_pkg::prod_t    pc_reg [3];
    vmb_pkg::prod_t    s1s_reg;
    vmb_pkg::rnd_t     r_v [3];
    vmb_pkg::rnd_t     r_s0, r_s2, r_s1;
    vmb_pkg::rnd_t     n_s0, n_s2, n_s1;

    logic              out_valid_reg;
    logic [31:0]       o_right_x_reg, o_right_z_reg;
    logic [2:0][31:0]  o_up_reg, o_fwd_reg;
    logic [33:0]       o_shx_reg, o_shy_reg, o_shz_reg;
    logic              o_deg_reg;

    assign en            = !out_valid_reg || view_out.ready;
    assign view_in.ready = en;

    always_comb
    begin
        look_vec[0]  = {view_in.look_x[31], view_in.look_x};
        look_vec[1]  = {view_in.look_y[31], view_in.look_y};
        look_vec[2]  = {view_in.look_z[31], view_in.look_z};
        // Right direction is (-look_z, 0, look_x); 33 bits keep -(-2^31) exact.
        right_vec[0] = ~{view_in.look_z[31], view_in.look_z} + 33'd1;
        right_vec[1] = '0;
        right_vec[2] = {view_in.look_x[31], view_in.look_x};
        cam_in.deg    = (view_in.look_x == '0) && (view_in.look_z == '0);
        cam_in.cam[0] = view_in.cam_x;
        cam_in.cam[1] = view_in.cam_y;
        cam_in.cam[2] = view_in.cam_z;
    end

    vmb_norm u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (view_in.valid),
        .vec       (look_vec),
        .out_valid (n_vld),
        .unit      (n_unit)
    );

    vmb_norm u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (view_in.valid),
        .vec       (right_vec),
        .out_valid (u_vld),
        .unit      (u_unit)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cam_dly_reg[0] <= cam_in;
            for (int i = 1; i < LAT; i++)
            begin
                cam_dly_reg[i] <= cam_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[3:0], n_vld && u_vld};
            out_valid_reg <= vld_reg[4];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_v[i] = vmb_pkg::round_unit(vs_reg[i]);
        end
        r_s0 = vmb_pkg::round_unit(s0s_reg);
        r_s2 = vmb_pkg::round_unit(s2s_reg);
        r_s1 = vmb_pkg::round_unit(s1s_reg);
        n_s0 = -r_s0;
        n_s2 = -r_s2;
        n_s1 = -r_s1;
        m3_next     = m2_reg;
        m3_next.sh0 = n_s0[33:0];
        m3_next.sh2 = n_s2[33:0];
        for (int i = 0; i < 3; i++)
        begin
            m3_next.v[i] = r_v[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Products of the unit rows and the camera.
            m1_reg.deg <= cam_dly_reg[LAT-1].deg;
            m1_reg.cam <= cam_dly_reg[LAT-1].cam;
            m1_reg.ux  <= u_unit[0];
            m1_reg.uz  <= u_unit[2];
            m1_reg.n   <= n_unit;
            m1_reg.v   <= '0;
            m1_reg.sh0 <= '0;
            m1_reg.sh2 <= '0;
            pv0_reg    <= vmb_pkg::smul(u_unit[2], n_unit[1]);
            pv1a_reg   <= vmb_pkg::smul(u_unit[2], n_unit[0]);
            pv1b_reg   <= vmb_pkg::smul(u_unit[0], n_unit[2]);
            pv2_reg    <= vmb_pkg::smul(u_unit[0], n_unit[1]);
            ps0a_reg   <= vmb_pkg::smul(u_unit[0], cam_dly_reg[LAT-1].cam[0]);
            ps0b_reg   <= vmb_pkg::smul(u_unit[2], cam_dly_reg[LAT-1].cam[2]);
            for (int i = 0; i < 3; i++)
            begin
                ps2_reg[i] <= vmb_pkg::smul(n_unit[i], cam_dly_reg[LAT-1].cam[i]);
            end

            // Sums.
            m2_reg    <= m1_reg;
            vs_reg[0] <= -pv0_reg;
            vs_reg[1] <= pv1a_reg - pv1b_reg;
            vs_reg[2] <= pv2_reg;
            s0s_reg   <= ps0a_reg + ps0b_reg;
            s2s_reg   <= ps2_reg[0] + ps2_reg[1] + ps2_reg[2];

            // Rounding of the up row and two translations.
            m3_reg <= m3_next;

            // Up row times the camera.
            m4_reg <= m3_reg;
            for (int i = 0; i < 3; i++)
            begin
                pc_reg[i] <= vmb_pkg::smul(m3_reg.v[i], m3_reg.cam[i]);
            end

            m5_reg  <= m4_reg;
            s1s_reg <= pc_reg[0] + pc_reg[1] + pc_reg[2];

            // Output register; a degenerate item shows all zero fields.
            o_deg_reg <= m5_reg.deg;
            if (m5_reg.deg)
            begin
                o_right_x_reg <= '0;
                o_right_z_reg <= '0;
                o_up_reg      <= '0;
                o_fwd_reg     <= '0;
                o_shx_reg     <= '0;
                o_shy_reg     <= '0;
                o_shz_reg     <= '0;
            end
            else
            begin
                o_right_x_reg <= m5_reg.ux;
                o_right_z_reg <= m5_reg.uz;
                o_up_reg      <= m5_reg.v;
                o_fwd_reg     <= m5_reg.n;
                o_shx_reg     <= m5_reg.sh0;
                o_shy_reg     <= n_s1[33:0];
                o_shz_reg     <= m5_reg.sh2;
            end
        end
    end

    assign view_out.valid      = out_valid_reg;
    assign view_out.right_x    = o_right_x_reg;
    assign view_out.right_z    = o_right_z_reg;
    assign view_out.up_x       = o_up_reg[0];
    assign view_out.up_y       = o_up_reg[1];
    assign view_out.up_z       = o_up_reg[2];
    assign view_out.fwd_x      = o_fwd_reg[0];
    assign view_out.fwd_y      = o_fwd_reg[1];
    assign view_out.fwd_z      = o_fwd_reg[2];
    assign view_out.shift_x    = o_shx_reg;
    assign view_out.shift_y    = o_shy_reg;
    assign view_out.shift_z    = o_shz_reg;
    assign view_out.degenerate = o_deg_reg;

endmodule

>>> rtl/vmb_checker.sv
// ----------------------------------------------------------------------------
// vmb_checker
// Port-level checks of the view matrix builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vmb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] right_x,
    input logic [31:0] right_z,
    input logic [31:0] fwd_x,
    input logic [31:0] fwd_y,
    input logic [31:0] fwd_z,
    input logic [33:0] shift_x,
    input logic [33:0] shift_y,
    input logic [33:0] shift_z,
    input logic        degenerate
);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(fwd_x) && $stable(shift_z) && $stable(degenerate),
        "stalled result changed")

    `ASSERT_IMPL(a_backpressure, out_valid && !out_ready, !in_ready,
        "request taken while the pipeline is frozen")

    `ASSERT_IMPL(a_degenerate_zero, out_valid && degenerate,
        right_x == '0 && right_z == '0 && fwd_x == '0 && fwd_y == '0 &&
        fwd_z == '0 && shift_x == '0 && shift_y == '0 && shift_z == '0,
        "degenerate result has nonzero fields")

    `ASSERT_IMPL(a_right_nonzero, out_valid && !degenerate,
        right_x != '0 || right_z != '0,
        "right row is zero for a valid direction")

endmodule

bind view_matrix_builder_unit vmb_checker u_vmb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (view_in.ready),
    .out_valid  (view_out.valid),
    .out_ready  (view_out.ready),
    .right_x    (view_out.right_x),
    .right_z    (view_out.right_z),
    .fwd_x      (view_out.fwd_x),
    .fwd_y      (view_out.fwd_y),
    .fwd_z      (view_out.fwd_z),
    .shift_x    (view_out.shift_x),
    .shift_y    (view_out.shift_y),
    .shift_z    (view_out.shift_z),
    .degenerate (view_out.degenerate)
);
